/* rtl/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, widths and constants of the five-sensor pid line follower
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // fixed point format and storage sizes
    localparam int INTEGRAL_WIDTH = 32;
    localparam int GAIN_FRAC_BITS = 24;

    localparam int GAIN_W     = 24;
    localparam int SPEED_W    = 16;
    localparam int SENSOR_W   = 8;
    localparam int THRESH_W   = 11;
    localparam int ERR_W      = 11;
    localparam int DERR_W     = ERR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // shared multiplier operands and product
    localparam int MUL_A_W = INTEGRAL_WIDTH + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // control value accumulator and wheel factor
    localparam int ACC_W   = MUL_P_W + 2;
    localparam int M_W     = ACC_W + 1;
    localparam int FRAC_SH = GAIN_FRAC_BITS + 1;
    localparam int Q_W     = 17;
    localparam int BIG_BIT = FRAC_SH + Q_W;
    localparam int W_W     = SPEED_W + Q_W + 1;

    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX =
        {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN =
        {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
    localparam logic signed [M_W-1:0] ONE_M =
        {{(M_W-FRAC_SH-1){1'b0}}, 1'b1, {FRAC_SH{1'b0}}};

    // register reset values
    localparam logic [SPEED_W-1:0]  BASE_SPEED_RST = 16'd12288;
    localparam logic [SPEED_W-1:0]  MAX_SPEED_RST  = 16'd40960;
    localparam logic [THRESH_W-1:0] LOST_THR_RST   = 11'd100;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_BASE_SPEED,
        REG_MAX_SPEED,
        REG_LOST_THRESHOLD
    } cfg_index_t;

    // input item modes
    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_RUN_START = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [SPEED_W-1:0]  base_speed;
        logic [SPEED_W-1:0]  max_speed;
        logic [THRESH_W-1:0] lost_threshold;
    } cfg_t;

    typedef struct packed {
        logic                mode;
        logic [SENSOR_W-1:0] sensor_far_left;
        logic [SENSOR_W-1:0] sensor_left;
        logic [SENSOR_W-1:0] sensor_center;
        logic [SENSOR_W-1:0] sensor_right;
        logic [SENSOR_W-1:0] sensor_far_right;
    } in_word_t;

    typedef struct packed {
        logic [SPEED_W-1:0] left_drive;
        logic [SPEED_W-1:0] right_drive;
        logic               off_track;
    } out_word_t;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_I,
        ST_D,
        ST_SUM,
        ST_MIX,
        ST_LQ,
        ST_LR,
        ST_RQ,
        ST_RR,
        ST_RFIN,
        ST_RCL,
        ST_DONE
    } state_t;

endpackage

/* rtl/lfpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfpd_cfg_regs
// Configuration register file: gains, speeds and lost-line threshold
// ----------------------------------------------------------------------------
module lfpd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lfpd_pkg::cfg_t                    cfg
);

    lfpd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.integ_gain     <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.base_speed     <= lfpd_pkg::BASE_SPEED_RST;
            cfg_reg.max_speed      <= lfpd_pkg::MAX_SPEED_RST;
            cfg_reg.lost_threshold <= lfpd_pkg::LOST_THR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lfpd_pkg::REG_PROP_GAIN: begin
                    cfg_reg.prop_gain <= cfg_data;
                end
                lfpd_pkg::REG_INTEG_GAIN: begin
                    cfg_reg.integ_gain <= cfg_data;
                end
                lfpd_pkg::REG_DERIV_GAIN: begin
                    cfg_reg.deriv_gain <= cfg_data;
                end
                lfpd_pkg::REG_BASE_SPEED: begin
                    cfg_reg.base_speed <= cfg_data[lfpd_pkg::SPEED_W-1:0];
                end
                lfpd_pkg::REG_MAX_SPEED: begin
                    cfg_reg.max_speed <= cfg_data[lfpd_pkg::SPEED_W-1:0];
                end
                lfpd_pkg::REG_LOST_THRESHOLD: begin
                    cfg_reg.lost_threshold <= cfg_data[lfpd_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/lfpd_mul.sv */
// ----------------------------------------------------------------------------
// lfpd_mul
// Shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module lfpd_mul (
    input  logic                                   aclk,
    input  lfpd_pkg::mul_req_t                     req,
    output logic signed [lfpd_pkg::MUL_P_W-1:0]    prod
);

    logic signed [lfpd_pkg::MUL_P_W-1:0] prod_reg;

    // one product per cycle, available the cycle after issue
    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/lfpd_seq.sv */
// ----------------------------------------------------------------------------
// lfpd_seq
// Sequencer and datapath: error, integral, pid sum and wheel speeds
// ----------------------------------------------------------------------------
module lfpd_seq (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lfpd_pkg::cfg_t                         cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  lfpd_pkg::in_word_t                     in_word,
    output lfpd_pkg::mul_req_t                     mul_req,
    input  logic signed [lfpd_pkg::MUL_P_W-1:0]    mul_prod,
    output lfpd_pkg::res_t                         res,
    input  logic                                   res_take
);

    localparam int IW = lfpd_pkg::INTEGRAL_WIDTH;
    localparam int EW = lfpd_pkg::ERR_W;
    localparam int DW = lfpd_pkg::DERR_W;
    localparam int AW = lfpd_pkg::MUL_A_W;
    localparam int BW = lfpd_pkg::MUL_B_W;
    localparam int PW = lfpd_pkg::MUL_P_W;
    localparam int CW = lfpd_pkg::ACC_W;
    localparam int MW = lfpd_pkg::M_W;
    localparam int SW = lfpd_pkg::SPEED_W;
    localparam int FS = lfpd_pkg::FRAC_SH;
    localparam int QW = lfpd_pkg::Q_W;
    localparam int WW = lfpd_pkg::W_W;
    localparam int XW = IW + 2;

    lfpd_pkg::state_t state_reg, state_next;

    // architectural state
    logic signed [EW-1:0] last_err_reg;
    logic signed [IW-1:0] integ_reg;

    // working registers
    logic signed [EW-1:0] e_reg;
    logic signed [DW-1:0] de_reg;
    logic signed [CW-1:0] acc_reg;
    logic signed [MW-1:0] ml_reg;
    logic signed [MW-1:0] mr_reg;
    logic [WW-1:0]        w_reg;
    logic [SW-1:0]        left_reg;
    logic [SW-1:0]        right_reg;
    logic                 off_reg;

    // accept-time front end
    logic                 accept;
    logic [lfpd_pkg::THRESH_W-1:0] sens_sum;
    logic                 lost;
    logic [EW-1:0]        e_raw;
    logic signed [EW-1:0] e_new;
    logic signed [XW-1:0] integ_sum;
    logic signed [IW-1:0] integ_new;
    logic signed [DW-1:0] de_new;

    // wheel stage helpers
    logic signed [PW-1:0] prod_x2;
    logic [SW-1:0]        prod_frac;

    // clamp one wheel factor and its partial speed to 0..max_speed
    function automatic logic [SW-1:0] wheel_clamp(
        input logic signed [MW-1:0] m,
        input logic [WW-1:0]        w,
        input logic [SW-1:0]        base,
        input logic [SW-1:0]        vmax
    );
        logic [SW-1:0] v;
        if (m[MW-1] || (m == '0) || (base == '0)) begin
            v = '0;
        end else if (|m[MW-2:lfpd_pkg::BIG_BIT]) begin
            v = vmax;
        end else if (w > {{(WW-SW){1'b0}}, vmax}) begin
            v = vmax;
        end else begin
            v = w[SW-1:0];
        end
        return v;
    endfunction

    assign accept = in_valid && in_ready;

    // sensor sum, weighted error and saturated doubled integral
    always_comb begin
        sens_sum = {3'b000, in_word.sensor_far_left} + {3'b000, in_word.sensor_left}
                 + {3'b000, in_word.sensor_center} + {3'b000, in_word.sensor_right}
                 + {3'b000, in_word.sensor_far_right};
        lost  = sens_sum < cfg.lost_threshold;
        e_raw = {2'b00, in_word.sensor_far_right, 1'b0}
              + {3'b000, in_word.sensor_right}
              - {3'b000, in_word.sensor_left}
              - {2'b00, in_word.sensor_far_left, 1'b0};
        e_new = $signed(e_raw);
        de_new = $signed({e_new[EW-1], e_new}) - $signed({last_err_reg[EW-1], last_err_reg});
        integ_sum = $signed({{2{integ_reg[IW-1]}}, integ_reg})
                  + $signed({{(XW-EW){last_err_reg[EW-1]}}, last_err_reg})
                  + $signed({{(XW-EW){e_new[EW-1]}}, e_new});
        if (integ_sum > $signed({{2{1'b0}}, lfpd_pkg::INT_MAX})) begin
            integ_new = lfpd_pkg::INT_MAX;
        end else if (integ_sum < $signed({{2{1'b1}}, lfpd_pkg::INT_MIN})) begin
            integ_new = lfpd_pkg::INT_MIN;
        end else begin
            integ_new = integ_sum[IW-1:0];
        end
    end

    assign prod_x2   = mul_prod <<< 1;
    assign prod_frac = mul_prod[FS +: SW];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfpd_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((in_word.mode == lfpd_pkg::MODE_SAMPLE) && !lost) begin
                        state_next = lfpd_pkg::ST_P;
                    end else begin
                        state_next = lfpd_pkg::ST_DONE;
                    end
                end
            end
            lfpd_pkg::ST_P:    state_next = lfpd_pkg::ST_I;
            lfpd_pkg::ST_I:    state_next = lfpd_pkg::ST_D;
            lfpd_pkg::ST_D:    state_next = lfpd_pkg::ST_SUM;
            lfpd_pkg::ST_SUM:  state_next = lfpd_pkg::ST_MIX;
            lfpd_pkg::ST_MIX:  state_next = lfpd_pkg::ST_LQ;
            lfpd_pkg::ST_LQ:   state_next = lfpd_pkg::ST_LR;
            lfpd_pkg::ST_LR:   state_next = lfpd_pkg::ST_RQ;
            lfpd_pkg::ST_RQ:   state_next = lfpd_pkg::ST_RR;
            lfpd_pkg::ST_RR:   state_next = lfpd_pkg::ST_RFIN;
            lfpd_pkg::ST_RFIN: state_next = lfpd_pkg::ST_RCL;
            lfpd_pkg::ST_RCL:  state_next = lfpd_pkg::ST_DONE;
            lfpd_pkg::ST_DONE: begin
                if (res_take) begin
                    state_next = lfpd_pkg::ST_IDLE;
                end
            end
            default: state_next = lfpd_pkg::ST_IDLE;
        endcase
    end

    // outputs: ready, multiplier operands, result offer
    always_comb begin
        in_ready  = 1'b0;
        res.valid = 1'b0;
        res.word.left_drive  = left_reg;
        res.word.right_drive = right_reg;
        res.word.off_track   = off_reg;
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            lfpd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            lfpd_pkg::ST_P: begin
                mul_req.a = {{(AW-EW){e_reg[EW-1]}}, e_reg};
                mul_req.b = {1'b0, cfg.prop_gain};
            end
            lfpd_pkg::ST_I: begin
                mul_req.a = {integ_reg[IW-1], integ_reg};
                mul_req.b = {1'b0, cfg.integ_gain};
            end
            lfpd_pkg::ST_D: begin
                mul_req.a = {{(AW-DW){de_reg[DW-1]}}, de_reg};
                mul_req.b = {1'b0, cfg.deriv_gain};
            end
            lfpd_pkg::ST_LQ: begin
                mul_req.a = {{(AW-QW){1'b0}}, ml_reg[FS +: QW]};
                mul_req.b = {{(BW-SW){1'b0}}, cfg.base_speed};
            end
            lfpd_pkg::ST_LR: begin
                mul_req.a = {{(AW-FS){1'b0}}, ml_reg[FS-1:0]};
                mul_req.b = {{(BW-SW){1'b0}}, cfg.base_speed};
            end
            lfpd_pkg::ST_RQ: begin
                mul_req.a = {{(AW-QW){1'b0}}, mr_reg[FS +: QW]};
                mul_req.b = {{(BW-SW){1'b0}}, cfg.base_speed};
            end
            lfpd_pkg::ST_RR: begin
                mul_req.a = {{(AW-FS){1'b0}}, mr_reg[FS-1:0]};
                mul_req.b = {{(BW-SW){1'b0}}, cfg.base_speed};
            end
            lfpd_pkg::ST_DONE: begin
                res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state register and pid state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfpd_pkg::ST_IDLE;
            last_err_reg <= '0;
            integ_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (in_word.mode == lfpd_pkg::MODE_RUN_START) begin
                    last_err_reg <= '0;
                    integ_reg    <= '0;
                end else if (!lost) begin
                    last_err_reg <= e_new;
                    integ_reg    <= integ_new;
                end
            end
        end
    end

    // datapath registers, product of the previous step used in each step
    always_ff @(posedge aclk) begin
        case (state_reg)
            lfpd_pkg::ST_IDLE: begin
                e_reg     <= e_new;
                de_reg    <= de_new;
                left_reg  <= '0;
                right_reg <= '0;
                off_reg   <= (in_word.mode == lfpd_pkg::MODE_SAMPLE) && lost;
            end
            lfpd_pkg::ST_I: begin
                acc_reg <= {{(CW-PW){prod_x2[PW-1]}}, prod_x2};
            end
            lfpd_pkg::ST_D: begin
                acc_reg <= acc_reg + {{(CW-PW){mul_prod[PW-1]}}, mul_prod};
            end
            lfpd_pkg::ST_SUM: begin
                acc_reg <= acc_reg + {{(CW-PW){prod_x2[PW-1]}}, prod_x2};
            end
            lfpd_pkg::ST_MIX: begin
                ml_reg <= lfpd_pkg::ONE_M + {{(MW-CW){acc_reg[CW-1]}}, acc_reg};
                mr_reg <= lfpd_pkg::ONE_M - {{(MW-CW){acc_reg[CW-1]}}, acc_reg};
            end
            lfpd_pkg::ST_LR: begin
                w_reg <= mul_prod[WW-1:0];
            end
            lfpd_pkg::ST_RQ: begin
                w_reg <= w_reg + {{(WW-SW){1'b0}}, prod_frac};
            end
            lfpd_pkg::ST_RR: begin
                left_reg <= wheel_clamp(ml_reg, w_reg, cfg.base_speed, cfg.max_speed);
                w_reg    <= mul_prod[WW-1:0];
            end
            lfpd_pkg::ST_RFIN: begin
                w_reg <= w_reg + {{(WW-SW){1'b0}}, prod_frac};
            end
            lfpd_pkg::ST_RCL: begin
                right_reg <= wheel_clamp(mr_reg, w_reg, cfg.base_speed, cfg.max_speed);
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/line_follow_pid_drive_top.sv */
// ----------------------------------------------------------------------------
// line_follow_pid_drive_top
// Five-sensor pid line follower producing left and right wheel speeds
// ----------------------------------------------------------------------------
// A sensor sample word is offered on the m_ side once the sequencer has run its
// states; s_ready stays low until the sequencer is idle again, so the block takes
// no new sample word before it is through with the last one. The sequence is set
// by the single shared 33 x 25 bit multiplier, which forms seven products in turn
// (proportional, integral and derivative terms, then the whole and fractional
// parts of each wheel speed) under a small sequencer, plus states to add the last
// term, form the two wheel factors, finish and clamp the right speed and hand the
// word to the output register. A run-start word or a word with the line lost
// skips the products: the sequencer goes straight from idle to the done state.
// A finished result sits in an output register, so the next word is taken while
// it waits for m_ready.
// Configuration writes are always ready and should be made while idle.
module line_follow_pid_drive_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lfpd_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lfpd_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lfpd_pkg::cfg_t                        cfg;
    lfpd_pkg::mul_req_t                    mul_req;
    logic signed [lfpd_pkg::MUL_P_W-1:0]   mul_prod;
    lfpd_pkg::res_t                        res;
    logic                                  res_take;
    logic                                  m_valid_reg;
    lfpd_pkg::out_word_t                   m_data_reg;

    lfpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfpd_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    lfpd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_word  (s_data),
        .mul_req  (mul_req),
        .mul_prod (mul_prod),
        .res      (res),
        .res_take (res_take)
    );

    // output register, refilled when empty or being drained
    assign res_take = res.valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_data_reg <= res.word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the five-sensor pid line follower. Sensor words
// are driven on the s_ side in random bursts, results are taken on the m_
// side under several stall styles, and every result is compared with a predictor
// that tracks the error, the doubled integral and the register settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int SHOW_MAX       = 10;
    localparam int FRAC           = GAIN_FRAC_BITS + 1;
    localparam int PHASE_WORDS    = 130;
    localparam int WINDUP_WORDS   = 200;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and the loop state
    cfg_t   drive_cfg;
    int     track_error;
    longint track_integral2;

    out_word_t pending_drive[$];
    int        mismatches = 0;

    // sender and receiver pacing
    bit        tx_gaps_on  = 1'b1;
    int        burst_left  = 0;
    rx_style_t rx_style    = RX_RANDOM;
    int        hold_ticket = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;
    int        rx_tick     = 0;

    line_follow_pid_drive_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        drive_cfg.prop_gain      = '0;
        drive_cfg.integ_gain     = '0;
        drive_cfg.deriv_gain     = '0;
        drive_cfg.base_speed     = BASE_SPEED_RST;
        drive_cfg.max_speed      = MAX_SPEED_RST;
        drive_cfg.lost_threshold = LOST_THR_RST;
        track_error              = 0;
        track_integral2          = 0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // integral contribution, capped far beyond wheel saturation
    function automatic longint integral_share();
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned lim;
        lim = 64'd1 << 60;
        if (drive_cfg.integ_gain == 0 || track_integral2 == 0) return 0;
        mag = (track_integral2 < 0) ? -track_integral2 : track_integral2;
        if (mag > lim / drive_cfg.integ_gain) prod = lim;
        else prod = mag * drive_cfg.integ_gain;
        if (prod > lim) prod = lim;
        return (track_integral2 < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // base * factor, factor in units of 2^-FRAC, clamped to 0..max
    function automatic logic [SPEED_W-1:0] wheel_speed(longint m);
        longint unsigned um;
        longint unsigned q;
        longint unsigned r;
        longint unsigned v;
        if (m <= 0 || drive_cfg.base_speed == 0) return '0;
        um = m;
        if (um >= (64'd1 << (GAIN_FRAC_BITS + 18))) return drive_cfg.max_speed;
        q = um >> FRAC;
        r = um & ((64'd1 << FRAC) - 1);
        v = q * drive_cfg.base_speed + ((r * drive_cfg.base_speed) >> FRAC);
        if (v > drive_cfg.max_speed) v = drive_cfg.max_speed;
        return v[SPEED_W-1:0];
    endfunction

    // expected wheel word for one accepted sensor word, updates loop state
    function automatic out_word_t predict_drive(in_word_t w);
        out_word_t res;
        int        sum;
        int        err;
        int        prev;
        longint    hi;
        longint    lo;
        longint    acc;
        longint    u;
        longint    one;
        res = '0;
        if (w.mode == MODE_RUN_START) begin
            track_error     = 0;
            track_integral2 = 0;
            return res;
        end
        sum = int'(w.sensor_far_left) + int'(w.sensor_left) + int'(w.sensor_center)
            + int'(w.sensor_right) + int'(w.sensor_far_right);
        if (sum < int'(drive_cfg.lost_threshold)) begin
            res.off_track = 1'b1;
            return res;
        end
        prev = track_error;
        err  = 2 * int'(w.sensor_far_right) + int'(w.sensor_right)
             - int'(w.sensor_left) - 2 * int'(w.sensor_far_left);
        // doubled trapezoidal integral, saturating
        hi  = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
        lo  = -hi - 1;
        acc = track_integral2 + prev + err;
        if (acc > hi) acc = hi;
        if (acc < lo) acc = lo;
        track_integral2 = acc;
        track_error     = err;
        u   = 2 * longint'(drive_cfg.prop_gain) * err + integral_share()
            + 2 * longint'(drive_cfg.deriv_gain) * (err - prev);
        one = longint'(1) <<< FRAC;
        res.left_drive  = wheel_speed(one + u);
        res.right_drive = wheel_speed(one - u);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // receiver: stall pattern plus long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 55);
                default:   m_ready <= ((rx_tick % 11) < 7);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("tb_top: unexpected word left=%0d right=%0d off=%0b",
                             m_data.left_drive, m_data.right_drive, m_data.off_track);
            end else begin
                want = pending_drive.pop_front();
                if (m_data.left_drive !== want.left_drive ||
                    m_data.right_drive !== want.right_drive ||
                    m_data.off_track !== want.off_track) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("tb_top: mismatch exp %0d %0d %0b got %0d %0d %0b",
                                 want.left_drive, want.right_drive, want.off_track,
                                 m_data.left_drive, m_data.right_drive,
                                 m_data.off_track);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared sender tasks
    // ------------------------------------------------------------------

    // offer one word, hold it until taken, then log its expectation
    task automatic send_word(input in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_drive.push_back(predict_drive(w));
    endtask

    // random gaps between bursts
    task automatic pace_sender();
        if (!tx_gaps_on) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge aclk);
        burst_left = $urandom_range(0, 24);
    endtask

    // stop offering and wait for every expected word, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PROP_GAIN:      drive_cfg.prop_gain      = val;
            REG_INTEG_GAIN:     drive_cfg.integ_gain     = val;
            REG_DERIV_GAIN:     drive_cfg.deriv_gain     = val;
            REG_BASE_SPEED:     drive_cfg.base_speed     = val[SPEED_W-1:0];
            REG_MAX_SPEED:      drive_cfg.max_speed      = val[SPEED_W-1:0];
            REG_LOST_THRESHOLD: drive_cfg.lost_threshold = val[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    // all six registers, only with the block idle
    task automatic apply_settings(input cfg_t c);
        wait_drained();
        write_reg(REG_PROP_GAIN, c.prop_gain);
        write_reg(REG_INTEG_GAIN, c.integ_gain);
        write_reg(REG_DERIV_GAIN, c.deriv_gain);
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(c.base_speed));
        write_reg(REG_MAX_SPEED, CFG_DATA_W'(c.max_speed));
        write_reg(REG_LOST_THRESHOLD, CFG_DATA_W'(c.lost_threshold));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // word and setting generators
    // ------------------------------------------------------------------
    function automatic in_word_t make_word(logic mode, int s0, int s1, int s2,
                                           int s3, int s4);
        in_word_t w;
        w.mode             = mode;
        w.sensor_far_left  = s0[SENSOR_W-1:0];
        w.sensor_left      = s1[SENSOR_W-1:0];
        w.sensor_center    = s2[SENSOR_W-1:0];
        w.sensor_right     = s3[SENSOR_W-1:0];
        w.sensor_far_right = s4[SENSOR_W-1:0];
        return w;
    endfunction

    // mostly line-shaped samples, some lost, some noise, few run starts
    function automatic in_word_t rand_word();
        int lvl[5];
        int pick;
        int pos;
        int span;
        int noise;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return make_word(MODE_RUN_START, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        if (pick < 15) begin
            foreach (lvl[k]) lvl[k] = $urandom_range(0, 60);
        end else if (pick < 40) begin
            foreach (lvl[k]) lvl[k] = $urandom_range(0, 255);
        end else begin
            pos = $urandom_range(0, 8);
            foreach (lvl[k]) begin
                span  = 2 * k - pos;
                if (span < 0) span = -span;
                noise = $urandom_range(0, 40);
                lvl[k] = 255 - 55 * span + noise - 20;
                if (lvl[k] < 0) lvl[k] = 0;
                if (lvl[k] > 255) lvl[k] = 255;
            end
        end
        return make_word(MODE_SAMPLE, lvl[0], lvl[1], lvl[2], lvl[3], lvl[4]);
    endfunction

    // log-spread gain so small and large gains both show up
    function automatic logic [GAIN_W-1:0] rand_gain();
        int unsigned mask;
        mask = (32'd1 << $urandom_range(0, GAIN_W)) - 1;
        return GAIN_W'($urandom & mask);
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t c;
        int   pick;
        c.prop_gain  = rand_gain();
        c.integ_gain = rand_gain();
        c.deriv_gain = rand_gain();
        pick = $urandom_range(0, 99);
        c.base_speed = (pick < 8) ? 16'd0 : (pick < 16) ? 16'hFFFF
                     : SPEED_W'($urandom_range(1024, 20480));
        pick = $urandom_range(0, 99);
        c.max_speed  = (pick < 8) ? 16'hFFFF : (pick < 12) ? 16'd0
                     : SPEED_W'($urandom_range(4096, 65535));
        pick = $urandom_range(0, 99);
        c.lost_threshold = (pick < 8) ? 11'd0 : (pick < 14) ? 11'd1275
                         : THRESH_W'($urandom_range(40, 400));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values, threshold edges and a run start
    task automatic test_reset_defaults();
        rx_style <= RX_ALWAYS;
        send_word(make_word(MODE_SAMPLE, 255, 255, 255, 255, 255));
        send_word(make_word(MODE_SAMPLE, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_SAMPLE, 20, 20, 20, 20, 20));
        send_word(make_word(MODE_SAMPLE, 20, 20, 20, 20, 19));
        send_word(make_word(MODE_SAMPLE, 0, 0, 60, 40, 10));
        send_word(make_word(MODE_RUN_START, 255, 255, 255, 255, 255));
        wait_drained();
    endtask

    // full-scale gains and speeds, extreme errors, base speed zero
    task automatic test_extremes();
        cfg_t c;
        c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1,
              base_speed: '1, max_speed: '1, lost_threshold: '0};
        apply_settings(c);
        rx_style <= RX_PATTERN;
        send_word(make_word(MODE_SAMPLE, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_SAMPLE, 0, 0, 255, 255, 255));
        send_word(make_word(MODE_SAMPLE, 255, 255, 255, 0, 0));
        send_word(make_word(MODE_SAMPLE, 0, 0, 0, 255, 255));
        send_word(make_word(MODE_RUN_START, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_SAMPLE, 0, 0, 0, 0, 1));

        c = '{prop_gain: 24'd40000, integ_gain: 24'd300, deriv_gain: 24'd9000,
              base_speed: '0, max_speed: '1, lost_threshold: 11'd1275};
        apply_settings(c);
        send_word(make_word(MODE_SAMPLE, 255, 255, 255, 255, 255));
        send_word(make_word(MODE_SAMPLE, 255, 255, 254, 255, 255));

        c = '{prop_gain: 24'd40000, integ_gain: 24'd300, deriv_gain: 24'd9000,
              base_speed: 16'd12288, max_speed: 16'd20000, lost_threshold: 11'd100};
        apply_settings(c);
        send_word(make_word(MODE_SAMPLE, 0, 0, 10, 200, 255));
        send_word(make_word(MODE_SAMPLE, 255, 200, 10, 0, 0));
        send_word(make_word(MODE_SAMPLE, 30, 200, 255, 200, 30));
        wait_drained();
    endtask

    // integral winds up until the factor saturates both wheels
    task automatic test_integral_windup();
        cfg_t c;
        c = '{prop_gain: '0, integ_gain: '1, deriv_gain: '0,
              base_speed: 16'd4096, max_speed: '1, lost_threshold: '0};
        apply_settings(c);
        rx_style   <= RX_RANDOM;
        tx_gaps_on = 1'b1;
        send_word(make_word(MODE_RUN_START, 0, 0, 0, 0, 0));
        repeat (WINDUP_WORDS) begin
            send_word(make_word(MODE_SAMPLE, $urandom_range(0, 8), $urandom_range(0, 8),
                                $urandom_range(0, 255), $urandom_range(247, 255),
                                $urandom_range(247, 255)));
            pace_sender();
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_output_hold();
        cfg_t c;
        c = rand_settings();
        apply_settings(c);
        rx_style    <= RX_ALWAYS;
        tx_gaps_on  = 1'b0;
        hold_ticket <= hold_ticket + 1;
        repeat (12) send_word(rand_word());
        wait_drained();
    endtask

    // sender stops until everything is back, then resumes
    task automatic test_pause_until_drained();
        rx_style   <= RX_PATTERN;
        tx_gaps_on = 1'b1;
        repeat (10) begin
            send_word(rand_word());
            pace_sender();
        end
        wait_drained();
        repeat (10) begin
            send_word(rand_word());
            pace_sender();
        end
        wait_drained();
    endtask

    // random words over several register settings and pacing styles
    task automatic test_random_phases();
        cfg_t c;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1,
                      base_speed: '1, max_speed: '1, lost_threshold: 11'd1275};
            else if (phase == 1)
                c = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0,
                      base_speed: '0, max_speed: '0, lost_threshold: '0};
            else
                c = rand_settings();
            apply_settings(c);
            case (phase % 3)
                0:       rx_style <= RX_ALWAYS;
                1:       rx_style <= RX_RANDOM;
                default: rx_style <= RX_PATTERN;
            endcase
            tx_gaps_on = (phase % 4 != 3);
            burst_left = 0;
            repeat (PHASE_WORDS) begin
                send_word(rand_word());
                pace_sender();
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int guard;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extremes();
        test_integral_windup();
        test_output_hold();
        test_pause_until_drained();
        test_random_phases();

        s_valid <= 1'b0;
        guard = 0;
        while (pending_drive.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // hard stop
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
